// ===== rtl/akm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// akm_pkg: opcodes, status codes, field widths and the control state type
// for the address-keyed map. No dependencies.

package akm_pkg;

    localparam int OP_W      = 2;
    localparam int VALUE_W   = 32;
    localparam int STAMP_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int ENTRY_W   = 9;
    localparam int BUCKET_W  = 10;

    // result transaction: status, found, value_out, entry_count, bucket_count
    localparam int OUT_FIELDS_W = STATUS_W + 1 + VALUE_W + ENTRY_W + BUCKET_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/address_keyed_map_with_load_resize.sv =====
`timescale 1ns / 1ps
`default_nettype none
// address_keyed_map_with_load_resize: bounded key to value map held in two
// simple dual-port synchronous memories, scanned one slot per cycle. Uses akm_pkg.

// After reset the block runs a clearing pass over every slot of the
// slot-used memory and takes no transaction until it ends. Each transaction
// is then worked alone. An add scans from slot 0 for the lowest free slot
// and stops there; a lookup or a remove scans every slot for the newest
// entry with the key. A refused add (zero value or full store) and an
// unknown opcode skip the scan and go straight to the result. Scans read the
// slot memories through their single registered read port. A new input
// transaction is taken while the previous result still waits on the output
// register. The bucket count is reported only; it does not steer where
// entries go.

module address_keyed_map_with_load_resize #(
    parameter int MAX_ENTRIES   = 256,
    parameter int START_BUCKETS = 64,
    parameter int KEY_BITS      = 48
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // op, key, value (lowest bit up), zero fill to whole bytes
    input  wire logic [((akm_pkg::OP_W + KEY_BITS + akm_pkg::VALUE_W + 7) / 8) * 8 - 1:0]
                                                      s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // status, found, value_out, entry_count, bucket_count (lowest bit up), zero fill
    output logic [akm_pkg::OUT_W-1:0]                 m_axis_tdata
);

    import akm_pkg::*;

    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int BW   = $clog2(8 * (MAX_ENTRIES + START_BUCKETS));
    localparam int DW   = KEY_BITS + VALUE_W + STAMP_W;
    localparam int TW   = BW + 2;
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ENTRIES - 1);

    // slot memories
    logic [DW-1:0]      r_data_mem [MAX_ENTRIES];
    logic               r_used_mem [MAX_ENTRIES];
    logic [DW-1:0]      r_rd_data;
    logic               r_rd_used;

    t_state             r_state;
    t_state             n_state;
    logic [AW-1:0]      r_addr;
    logic               r_iss_done;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_idx;
    logic [CW-1:0]      r_count;
    logic [BW-1:0]      r_buckets;
    logic [STAMP_W-1:0] r_next_stamp;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    // captured item and scan results
    logic [OP_W-1:0]     r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [VALUE_W-1:0]  r_value;
    logic                r_hit;
    logic [AW-1:0]       r_best_idx;
    logic [STAMP_W-1:0]  r_best_age;
    logic [VALUE_W-1:0]  r_best_val;
    logic                r_free_ok;
    logic [AW-1:0]       r_free_idx;
    logic [STATUS_W-1:0] r_res_status;
    logic                r_res_found;
    logic [VALUE_W-1:0]  r_res_value;

    // combinational control
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_data_we;
    logic               w_used_we;
    logic               w_used_val;
    logic [AW-1:0]      w_waddr;
    logic [DW-1:0]      w_wdata;

    logic [OP_W-1:0]     w_in_op;
    logic [KEY_BITS-1:0] w_in_key;
    logic [VALUE_W-1:0]  w_in_value;

    logic [KEY_BITS-1:0] w_rd_key;
    logic [VALUE_W-1:0]  w_rd_val;
    logic [STAMP_W-1:0]  w_rd_stamp;
    logic [STAMP_W-1:0]  w_age;
    logic                w_match;
    logic                w_better;
    logic                w_free_hit;
    logic                w_scan_end;

    logic [TW-1:0]       w_cnt_plus;
    logic [TW-1:0]       w_grow_thr;
    logic                w_grow;
    logic                w_shrink;
    logic                w_full;
    logic                w_start_scan;

    assign w_in_op    = s_axis_tdata[OP_W-1:0];
    assign w_in_key   = s_axis_tdata[OP_W+KEY_BITS-1:OP_W];
    assign w_in_value = s_axis_tdata[OP_W+KEY_BITS+VALUE_W-1:OP_W+KEY_BITS];

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign w_rd_key   = r_rd_data[KEY_BITS-1:0];
    assign w_rd_val   = r_rd_data[KEY_BITS+VALUE_W-1:KEY_BITS];
    assign w_rd_stamp = r_rd_data[DW-1:KEY_BITS+VALUE_W];
    assign w_age      = r_next_stamp - w_rd_stamp;
    assign w_match    = r_rd_used && (w_rd_key == r_key);
    assign w_better   = w_match && (!r_hit || (w_age < r_best_age));
    assign w_free_hit = r_rd_vld && (r_op == OP_ADD) && !r_rd_used;
    assign w_scan_end = r_rd_vld && (w_free_hit || (r_rd_idx == LAST_IDX));

    // load checks, evaluated on the counts held before the transaction
    assign w_cnt_plus = TW'(r_count) + TW'(1);
    assign w_grow_thr = (TW'(r_buckets) + (TW'(r_buckets) << 1)) >> 2;
    assign w_grow     = w_cnt_plus > w_grow_thr;
    assign w_shrink   = (r_buckets > BW'(START_BUCKETS))
                     && (TW'(r_count) < (TW'(r_buckets >> 2) + TW'(1)));
    assign w_full     = r_count >= CW'(MAX_ENTRIES);
    assign w_start_scan = ((w_in_op == OP_ADD) && (w_in_value != '0) && !w_full)
                       || (w_in_op == OP_LOOKUP) || (w_in_op == OP_REMOVE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST_IDX) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_acc) n_state = w_start_scan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (w_scan_end) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs: handshake and memory write port
    always_comb begin
        s_axis_tready = 1'b0;
        w_data_we     = 1'b0;
        w_used_we     = 1'b0;
        w_used_val    = 1'b0;
        w_waddr       = r_addr;
        w_wdata       = {r_next_stamp, r_value, r_key};
        case (r_state)
            S_CLEAR: begin
                w_used_we = 1'b1;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_COMMIT: begin
                if (r_op == OP_ADD) begin
                    w_waddr    = r_free_idx;
                    w_data_we  = r_free_ok;
                    w_used_we  = r_free_ok;
                    w_used_val = 1'b1;
                end else if (r_op == OP_REMOVE) begin
                    w_waddr   = r_best_idx;
                    w_used_we = r_hit;
                end
            end
            default: begin
            end
        endcase
    end

    // slot data memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_data_we) r_data_mem[w_waddr] <= w_wdata;
        r_rd_data <= r_data_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_used_we) r_used_mem[w_waddr] <= w_used_val;
        r_rd_used <= r_used_mem[r_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_iss_done   <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_count      <= '0;
            r_buckets    <= BW'(START_BUCKETS);
            r_next_stamp <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_addr <= (r_addr == LAST_IDX) ? '0 : r_addr + AW'(1);
                end
                S_IDLE: begin
                    r_addr     <= '0;
                    r_iss_done <= 1'b0;
                    if (w_in_acc) begin
                        if ((w_in_op == OP_ADD) && (w_in_value != '0) && w_grow)
                            r_buckets <= r_buckets << 1;
                        if ((w_in_op == OP_REMOVE) && w_shrink)
                            r_buckets <= r_buckets >> 1;
                    end
                end
                S_SCAN: begin
                    // stop issuing reads once the scan has its answer
                    if (!r_iss_done && !w_scan_end) begin
                        r_rd_vld <= 1'b1;
                        if (r_addr == LAST_IDX) r_iss_done <= 1'b1;
                        else                    r_addr     <= r_addr + AW'(1);
                    end
                end
                S_COMMIT: begin
                    if ((r_op == OP_ADD) && r_free_ok) begin
                        r_count      <= r_count + CW'(1);
                        r_next_stamp <= r_next_stamp + STAMP_W'(1);
                    end else if ((r_op == OP_REMOVE) && r_hit && (r_count != '0)) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                default: begin
                end
            endcase
            if (r_state == S_DONE && w_out_free) r_out_valid <= 1'b1;
            else if (m_axis_tready)              r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) r_rd_idx <= r_addr;
        case (r_state)
            S_IDLE: begin
                r_op         <= w_in_op;
                r_key        <= w_in_key;
                r_value      <= w_in_value;
                r_hit        <= 1'b0;
                r_free_ok    <= 1'b0;
                r_res_status <= STS_DONE;
                r_res_found  <= 1'b0;
                r_res_value  <= '0;
                if ((w_in_op == OP_ADD) && (w_in_value == '0)) r_res_status <= STS_ZERO;
                else if ((w_in_op == OP_ADD) && w_full)        r_res_status <= STS_FULL;
            end
            S_SCAN: begin
                if (w_free_hit) begin
                    r_free_ok  <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
                if (r_rd_vld && (r_op != OP_ADD) && w_better) begin
                    r_hit      <= 1'b1;
                    r_best_idx <= r_rd_idx;
                    r_best_age <= w_age;
                    r_best_val <= w_rd_val;
                end
            end
            S_COMMIT: begin
                if (r_op == OP_ADD) begin
                    r_res_status <= r_free_ok ? STS_DONE : STS_FULL;
                end else begin
                    r_res_found <= r_hit;
                    r_res_value <= r_hit ? r_best_val : '0;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_data <= OUT_W'({BUCKET_W'(r_buckets), ENTRY_W'(r_count),
                                          r_res_value, r_res_found, r_res_status});
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_bucket_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buckets >= BW'(START_BUCKETS))
        else $error("bucket count below start value");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside the done state");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_op == OP_REMOVE && r_hit && r_count != '0)
        |=> r_count == $past(r_count) - CW'(1))
        else $error("remove hit did not lower the entry count");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_IDLE) |-> !w_used_we && !w_data_we)
        else $error("slot memory written while scanning or idle");

endmodule

`default_nettype wire
